/* rtl/rhcm_pkg.sv */
// Shared types and constants for the Mersenne-prime hash concatenation block.
// No dependencies; used by rhcm_ctrl, rhcm_datapath and the top level.
package rhcm_pkg;

    // Field widths of the stream payloads
    localparam int FIELD_W     = 61;
    localparam int LEN_W       = 32;
    localparam int IN_TDATA_W  = ((2 * FIELD_W + LEN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((FIELD_W + 7) / 8) * 8;

    // Defaults for the top-level parameters
    localparam int DEF_MERSENNE_EXP = 61;
    localparam int DEF_LEN_BITS     = 32;

    // Operations of the shared modular multiplier
    typedef logic [1:0] t_op;
    localparam t_op OP_SQR = 2'd0;   // sq  <- sq * sq
    localparam t_op OP_MUL = 2'd1;   // acc <- acc * sq when exponent bit set
    localparam t_op OP_FIN = 2'd2;   // acc <- left * acc
    localparam t_op OP_ADD = 2'd3;   // out <- acc + right

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture input item, init sq/acc/exponent
        logic op_valid;   // issue op this cycle
        t_op  op;
    } t_cmd;

endpackage

/* rtl/rhcm_datapath.sv */
// Datapath: operand registers, 3-stage pipelined Mersenne modular multiplier,
// output register. Driven by rhcm_ctrl through rhcm_pkg::t_cmd.
module rhcm_datapath #(
    parameter int MERSENNE_EXP = rhcm_pkg::DEF_MERSENNE_EXP,
    parameter int LEN_BITS     = rhcm_pkg::DEF_LEN_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rhcm_pkg::FIELD_W-1:0]     i_cfg_data,
    input  rhcm_pkg::t_cmd                   i_cmd,
    input  logic [rhcm_pkg::FIELD_W-1:0]     i_left,
    input  logic [rhcm_pkg::FIELD_W-1:0]     i_right,
    input  logic [rhcm_pkg::LEN_W-1:0]       i_len,
    input  logic                             i_out_take,
    output logic                             o_out_full,
    output logic [rhcm_pkg::FIELD_W-1:0]     o_out_data
);

    localparam int ME  = MERSENNE_EXP;
    localparam int SW  = ME + 1;
    localparam int PW  = 2 * ME;
    localparam int HB  = (ME > 32) ? (ME - 32) : 1;
    localparam int OPW = 32 + HB;
    localparam int FW  = 2 * OPW;
    localparam logic [ME-1:0] P = '1;

    // write-back destinations carried down the pipeline
    localparam logic [1:0] DST_NONE = 2'd0;
    localparam logic [1:0] DST_SQ   = 2'd1;
    localparam logic [1:0] DST_ACC  = 2'd2;
    localparam logic [1:0] DST_OUT  = 2'd3;

    // fold a product (or sum) below 2^(2*ME) into [0, p)
    function automatic logic [ME-1:0] mod_fold(input logic [PW-1:0] x);
        logic [SW-1:0] s1;
        logic [SW-1:0] s2;
        s1 = {1'b0, x[ME-1:0]} + {1'b0, x[PW-1:ME]};
        s2 = {1'b0, s1[ME-1:0]} + SW'(s1[ME]);
        mod_fold = (s2[ME-1:0] == P) ? '0 : s2[ME-1:0];
    endfunction

    // reduce a raw input field into [0, p)
    function automatic logic [ME-1:0] in_fold(input logic [rhcm_pkg::FIELD_W-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        t = (t & 64'(P)) + (t >> ME);
        t = (t & 64'(P)) + (t >> ME);
        in_fold = (t == 64'(P)) ? '0 : ME'(t);
    endfunction

    logic [rhcm_pkg::FIELD_W-1:0] r_base;
    logic [ME-1:0]       r_left, r_right, r_sq, r_acc;
    logic [LEN_BITS-1:0] r_exp;

    logic [OPW-1:0]      op_a, op_b;
    logic [1:0]          n_tag1, r_tag1, n_tag2, r_tag2;
    logic [63:0]         n_p00;
    logic [31+HB:0]      n_p01, n_p10;
    logic [2*HB-1:0]     n_p11;
    logic [63:0]         r_p00;
    logic [31+HB:0]      r_p01, r_p10;
    logic [2*HB-1:0]     r_p11;
    logic [FW-1:0]       prod_sum;
    logic [PW-1:0]       r_prod;
    logic [ME-1:0]       red;
    logic                is_add;
    logic [rhcm_pkg::FIELD_W-1:0] r_out;
    logic                r_out_full;

    assign is_add = i_cmd.op_valid && (i_cmd.op == rhcm_pkg::OP_ADD);

    // stage 1: operand select, 32-bit partial products
    always_comb begin
        op_a   = OPW'(r_sq);
        op_b   = OPW'(r_sq);
        n_tag1 = DST_NONE;
        case (i_cmd.op)
            rhcm_pkg::OP_SQR: begin
                n_tag1 = DST_SQ;
            end
            rhcm_pkg::OP_MUL: begin
                op_a   = OPW'(r_acc);
                n_tag1 = r_exp[0] ? DST_ACC : DST_NONE;
            end
            rhcm_pkg::OP_FIN: begin
                op_a   = OPW'(r_left);
                op_b   = OPW'(r_acc);
                n_tag1 = DST_ACC;
            end
            default: begin
                n_tag1 = DST_NONE;
            end
        endcase
        if (!i_cmd.op_valid) begin
            n_tag1 = DST_NONE;
        end
    end

    assign n_p00 = op_a[31:0]    * op_b[31:0];
    assign n_p01 = op_a[31:0]    * op_b[OPW-1:32];
    assign n_p10 = op_a[OPW-1:32] * op_b[31:0];
    assign n_p11 = op_a[OPW-1:32] * op_b[OPW-1:32];

    // stage 2: combine partials (or take the final add)
    assign prod_sum = FW'(r_p00) + (FW'(r_p01) << 32) + (FW'(r_p10) << 32)
                    + (FW'(r_p11) << 64);
    assign n_tag2   = is_add ? DST_OUT : r_tag1;

    // stage 3: Mersenne reduction
    assign red = mod_fold(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_tag1     <= DST_NONE;
            r_tag2     <= DST_NONE;
            r_out_full <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            r_tag1 <= n_tag1;
            r_tag2 <= n_tag2;
            if (i_out_take) begin
                r_out_full <= 1'b0;
            end
            if (r_tag2 == DST_OUT) begin
                r_out_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p00 <= n_p00;
        r_p01 <= n_p01;
        r_p10 <= n_p10;
        r_p11 <= n_p11;
        if (is_add) begin
            r_prod <= PW'({1'b0, r_acc} + {1'b0, r_right});
        end else begin
            r_prod <= PW'(prod_sum);
        end
        if (i_cmd.load) begin
            r_left  <= in_fold(i_left);
            r_right <= in_fold(i_right);
            r_exp   <= LEN_BITS'(i_len);
            r_sq    <= in_fold(r_base);
            r_acc   <= ME'(1);
        end else begin
            if (i_cmd.op_valid && (i_cmd.op == rhcm_pkg::OP_MUL)) begin
                r_exp <= r_exp >> 1;
            end
            case (r_tag2)
                DST_SQ:  r_sq  <= red;
                DST_ACC: r_acc <= red;
                DST_OUT: r_out <= rhcm_pkg::FIELD_W'(red);
                default: ;
            endcase
        end
    end

    assign o_out_full = r_out_full;
    assign o_out_data = r_out;

`ifndef NO_ASSERTIONS
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag2 == DST_OUT) |-> (!r_out_full || i_out_take))
        else $error("result written over an untaken result");
    a_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag2 != DST_NONE) |-> (red != P))
        else $error("reduction left p unmapped");
    a_no_load_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> ((r_tag1 == DST_NONE) && (r_tag2 == DST_NONE)))
        else $error("item loaded while multiplier still writing back");
`endif

endmodule

/* rtl/rhcm_ctrl.sv */
// Controller: sequences load, square/multiply rounds, final multiply and add.
// Depends on rhcm_pkg for the command struct and op codes.
module rhcm_ctrl #(
    parameter int LEN_BITS = rhcm_pkg::DEF_LEN_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_full,
    output rhcm_pkg::t_cmd o_cmd
);

    localparam int CW = (LEN_BITS > 1) ? $clog2(LEN_BITS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQR   = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_GAP   = 4'd3;
    localparam logic [3:0] S_GAP2  = 4'd4;
    localparam logic [3:0] S_FIN   = 4'd5;
    localparam logic [3:0] S_FW1   = 4'd6;
    localparam logic [3:0] S_FW2   = 4'd7;
    localparam logic [3:0] S_ADD   = 4'd8;
    localparam logic [3:0] S_DRAIN = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.op_valid = 1'b0;
        o_cmd.op       = rhcm_pkg::OP_SQR;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.op_valid = 1'b1;
                o_cmd.op       = rhcm_pkg::OP_SQR;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.op_valid = 1'b1;
                o_cmd.op       = rhcm_pkg::OP_MUL;
                n_state        = S_GAP;
            end
            S_GAP: begin
                if (r_cnt == CW'(LEN_BITS - 1)) begin
                    n_state = S_GAP2;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_SQR;
                end
            end
            S_GAP2: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.op_valid = 1'b1;
                o_cmd.op       = rhcm_pkg::OP_FIN;
                n_state        = S_FW1;
            end
            S_FW1: begin
                n_state = S_FW2;
            end
            S_FW2: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                if (!i_out_full) begin
                    o_cmd.op_valid = 1'b1;
                    o_cmd.op       = rhcm_pkg::OP_ADD;
                    n_state        = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_add_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op_valid && (o_cmd.op == rhcm_pkg::OP_ADD)) |-> !i_out_full)
        else $error("final add issued while result register full");
`endif

endmodule

/* rtl/rolling_hash_concat_mersenne_top.sv */
// Top level of the Mersenne-prime hash concatenation block.
// Instantiates rhcm_ctrl and rhcm_datapath; types and widths from rhcm_pkg.
//
// Returns joined = (left * base^len + right) mod p with p = 2^MERSENNE_EXP - 1,
// the polynomial rolling hash of two strings joined, given each string's hash and
// the right string's length. Operands at or above p are reduced first, so p reads
// as 0. The base is a 61-bit register written on the cfg channel (reset 0,
// always ready); write it only while the block is idle. One item is worked on
// at a time: the controller takes an item, runs LEN_BITS rounds of
// square-and-multiply over the length bits (LSB first) on one shared
// three-stage pipelined 61x61 modular multiplier, then a final multiply and
// an add. Each round holds an idle gap state after its square and multiply
// because the next square needs the previous square's write-back. The next
// input transfer comes only once the controller is back in idle after the
// add, so a new item is not taken before the last one has issued its add. The
// output register lets the next item be taken while a result waits; only the
// final add stalls when the previous result is still untaken.
module rolling_hash_concat_mersenne_top #(
    parameter int MERSENNE_EXP = rhcm_pkg::DEF_MERSENNE_EXP,
    parameter int LEN_BITS     = rhcm_pkg::DEF_LEN_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write: hash_base
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rhcm_pkg::FIELD_W-1:0]        i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: left_value [60:0], right_value [121:61], right_length [153:122]
    input  logic [rhcm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: joined_value [60:0]
    output logic [rhcm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int FW = rhcm_pkg::FIELD_W;
    localparam int LW = rhcm_pkg::LEN_W;

    rhcm_pkg::t_cmd cmd;
    logic           out_full;
    logic [FW-1:0]  out_data;

    assign o_cfg_ready = 1'b1;

    rhcm_ctrl #(
        .LEN_BITS (LEN_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_full (out_full),
        .o_cmd      (cmd)
    );

    rhcm_datapath #(
        .MERSENNE_EXP (MERSENNE_EXP),
        .LEN_BITS     (LEN_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_left     (s_axis_tdata[FW-1:0]),
        .i_right    (s_axis_tdata[2*FW-1:FW]),
        .i_len      (s_axis_tdata[2*FW+LW-1:2*FW]),
        .i_out_take (m_axis_tready),
        .o_out_full (out_full),
        .o_out_data (out_data)
    );

    assign m_axis_tvalid = out_full;
    assign m_axis_tdata  = rhcm_pkg::OUT_TDATA_W'(out_data);

`ifndef NO_ASSERTIONS
    // a result only appears at the end of an item, never while taking input
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while block was idle");
`endif

endmodule

/* tb/tb_rolling_hash_concat_mersenne_top.sv */
// Self-checking testbench for rolling_hash_concat_mersenne_top: joined hash mod 2^61-1.
// Depends on rhcm_pkg for the stream widths; holds its own wide-arithmetic predictor.
module tb_rolling_hash_concat_mersenne_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_W     = rhcm_pkg::FIELD_W;
    localparam int LEN_W       = rhcm_pkg::LEN_W;
    localparam int IN_TDATA_W  = rhcm_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = rhcm_pkg::OUT_TDATA_W;

    localparam logic [FIELD_W-1:0] P_MOD    = {FIELD_W{1'b1}};  // Mersenne prime 2^61-1
    localparam logic [FIELD_W-1:0] P_MINUS1 = P_MOD - 1'b1;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int NUM_PHASES      = 5;
    localparam int HOLD_AT         = 150;    // transfer count that triggers the long output hold
    localparam int HOLD_CYCLES     = 800;
    localparam int TAIL_CYCLES     = 120;    // longer than one item's period
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [FIELD_W-1:0]     i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // left_value, right_value, right_length (low to high)
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // joined_value

    rolling_hash_concat_mersenne_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Directed stimulus: either a base write or one item. The joined value is typed
    // in only where it is obvious; otherwise the predictor supplies it.
    typedef struct {
        bit                 set_base;
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] left;
        logic [FIELD_W-1:0] right;
        logic [LEN_W-1:0]   len;
        bit                 typed;
        logic [FIELD_W-1:0] joined;
    } t_dir_row;

    t_dir_row           dir_tab[$];
    logic [FIELD_W-1:0] joined_q[$];     // expected joined hashes, oldest first
    logic [FIELD_W-1:0] base_reg = '0;   // mirror of the hash_base register
    bit                 idle_on = 1'b1;  // random gaps on both sides
    bit                 hold_req = 1'b0; // asks the result side for one long hold
    int                 sent = 0;
    int                 errors = 0;
    int unsigned        cycles = 0;

    // ---------------------------------------------------------------- predictor
    function automatic logic [FIELD_W-1:0] mod_p(input logic [127:0] x);
        logic [127:0] r;
        r = x % {{(128 - FIELD_W){1'b0}}, P_MOD};
        return r[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] mul_mod(input logic [FIELD_W-1:0] a,
                                                   input logic [FIELD_W-1:0] b);
        logic [127:0] prod;
        prod = {{(128 - FIELD_W){1'b0}}, a} * {{(128 - FIELD_W){1'b0}}, b};
        return mod_p(prod);
    endfunction

    // base^len mod p, one square per length bit, LSB first
    function automatic logic [FIELD_W-1:0] base_power(input logic [FIELD_W-1:0] base,
                                                      input logic [LEN_W-1:0] len);
        logic [FIELD_W-1:0] sq;
        logic [FIELD_W-1:0] acc;
        sq  = mod_p({{(128 - FIELD_W){1'b0}}, base});
        acc = 1;
        for (int i = 0; i < LEN_W; i++) begin
            if (len[i])
                acc = mul_mod(acc, sq);
            sq = mul_mod(sq, sq);
        end
        return acc;
    endfunction

    function automatic logic [FIELD_W-1:0] joined_hash(input logic [FIELD_W-1:0] left,
                                                       input logic [FIELD_W-1:0] right,
                                                       input logic [LEN_W-1:0] len);
        logic [FIELD_W-1:0] t;
        t = mul_mod(mod_p({{(128 - FIELD_W){1'b0}}, left}), base_power(base_reg, len));
        return mod_p({{(128 - FIELD_W){1'b0}}, t}
                     + {{(128 - FIELD_W){1'b0}}, mod_p({{(128 - FIELD_W){1'b0}}, right})});
    endfunction

    // ---------------------------------------------------------------- random values
    function automatic logic [FIELD_W-1:0] rand61();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[FIELD_W-1:0];
    endfunction

    // Hash operands lean on zero, p itself and p-1
    function automatic logic [FIELD_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return P_MOD;
            2:       return P_MINUS1;
            default: return rand61();
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return LEN_W'($urandom_range(1, 64));
            3:       return LEN_W'(1) << $urandom_range(0, LEN_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------- input side
    // Offer one item and hold it until the transfer; the expectation is queued at
    // the accepting edge. A random gap may follow.
    task automatic send_item(input logic [FIELD_W-1:0] left, input logic [FIELD_W-1:0] right,
                             input logic [LEN_W-1:0] len, input bit typed,
                             input logic [FIELD_W-1:0] typed_val);
        logic [IN_TDATA_W-1:0] word;
        logic [FIELD_W-1:0]    want;
        want = typed ? typed_val : joined_hash(left, right, len);
        word = '0;
        word[FIELD_W-1:0]                 = left;
        word[2*FIELD_W-1:FIELD_W]         = right;
        word[2*FIELD_W+LEN_W-1:2*FIELD_W] = len;
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        joined_q.push_back(want);
        sent++;
        if (sent == HOLD_AT)
            hold_req = 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Base writes happen only with the block drained
    task automatic write_base(input logic [FIELD_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (joined_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        base_reg = value;
    endtask

    // ---------------------------------------------------------------- result side
    // Samples each transfer and checks it against the oldest expectation. Also
    // owns tready: short random stalls, plus one long hold counted here so the
    // output register and the pipeline fill up and the input side stalls.
    initial begin
        logic [FIELD_W-1:0] want;
        logic [FIELD_W-1:0] got;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[FIELD_W-1:0];
                if (joined_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected joined_value transfer, expected none, actual %h",
                             $time, got);
                end else begin
                    want = joined_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: joined_value mismatch, expected %h, actual %h",
                                 $time, want, got);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on total run length
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence
    initial begin
        logic [FIELD_W-1:0] next_base;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;

        // base 0 from reset: power is 1 for length 0 and 0 otherwise
        dir_tab.push_back('{1'b0, '0, 61'd5, 61'd7, 32'd0, 1'b1, 61'd12});
        dir_tab.push_back('{1'b0, '0, P_MOD, P_MOD, 32'd0, 1'b1, 61'd0});
        dir_tab.push_back('{1'b0, '0, P_MINUS1, 61'd1, 32'd0, 1'b1, 61'd0});
        dir_tab.push_back('{1'b0, '0, P_MINUS1, P_MINUS1, 32'd0, 1'b1, P_MOD - 61'd2});
        dir_tab.push_back('{1'b0, '0, 61'd123, 61'd456, 32'd1, 1'b1, 61'd456});
        dir_tab.push_back('{1'b0, '0, P_MINUS1, 61'd0, 32'hFFFF_FFFF, 1'b1, 61'd0});
        dir_tab.push_back('{1'b0, '0, 61'd0, P_MINUS1, 32'd7, 1'b1, P_MINUS1});
        // base 1: plain sum
        dir_tab.push_back('{1'b1, 61'd1, '0, '0, '0, 1'b0, '0});
        dir_tab.push_back('{1'b0, '0, P_MINUS1, 61'd5, 32'hFFFF_FFFF, 1'b1, 61'd4});
        // base 2: 2^61 wraps to 1
        dir_tab.push_back('{1'b1, 61'd2, '0, '0, '0, 1'b0, '0});
        dir_tab.push_back('{1'b0, '0, 61'd1, 61'd0, 32'd3, 1'b1, 61'd8});
        dir_tab.push_back('{1'b0, '0, 61'd9, 61'd0, 32'd61, 1'b1, 61'd9});
        dir_tab.push_back('{1'b0, '0, 61'd2, 61'd0, 32'd60, 1'b1, 61'd1});
        // base equal to p behaves as 0
        dir_tab.push_back('{1'b1, P_MOD, '0, '0, '0, 1'b0, '0});
        dir_tab.push_back('{1'b0, '0, 61'd7, 61'd3, 32'd5, 1'b1, 61'd3});
        dir_tab.push_back('{1'b0, '0, 61'd7, 61'd3, 32'd0, 1'b1, 61'd10});
        // base p-1 is -1: sign follows length parity
        dir_tab.push_back('{1'b1, P_MINUS1, '0, '0, '0, 1'b0, '0});
        dir_tab.push_back('{1'b0, '0, 61'd1, 61'd0, 32'd1, 1'b1, P_MINUS1});
        dir_tab.push_back('{1'b0, '0, 61'd1, 61'd0, 32'd2, 1'b1, 61'd1});
        dir_tab.push_back('{1'b0, '0, 61'd3, 61'd4, 32'hFFFF_FFFF, 1'b1, 61'd1});
        // arbitrary base, predictor-checked
        dir_tab.push_back('{1'b1, 61'h0123_4567_89AB_CDEF, '0, '0, '0, 1'b0, '0});
        dir_tab.push_back('{1'b0, '0, 61'h1555_5555_5555_5555, 61'h0AAA_AAAA_AAAA_AAAA,
                            32'hAAAA_AAAA, 1'b0, '0});
        dir_tab.push_back('{1'b0, '0, P_MINUS1, P_MINUS1, 32'h8000_0000, 1'b0, '0});
        dir_tab.push_back('{1'b0, '0, 61'h1000_0000_0000_0000, 61'd0, 32'h0000_FFFF,
                            1'b0, '0});
        dir_tab.push_back('{1'b0, '0, 61'h0FED_CBA9_8765_4321, 61'd1, 32'h5555_5555,
                            1'b0, '0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].set_base)
                write_base(dir_tab[k].base);
            else
                send_item(dir_tab[k].left, dir_tab[k].right, dir_tab[k].len,
                          dir_tab[k].typed, dir_tab[k].joined);
        end

        // Random phases, each with its own base; the long hold lands in phase 1
        // and the final phase runs with both sides always ready.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       next_base = P_MINUS1;
                2:       next_base = '0;
                default: next_base = rand61();
            endcase
            write_base(next_base);
            idle_on = (ph != NUM_PHASES - 1);
            repeat (ITEMS_PER_PHASE)
                send_item(pick_operand(), pick_operand(), pick_length(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (joined_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
rtl/rhcm_pkg.sv
rtl/rhcm_datapath.sv
rtl/rhcm_ctrl.sv
rtl/rolling_hash_concat_mersenne_top.sv
tb/tb_rolling_hash_concat_mersenne_top.sv
